// ===== design/prime_sieve_engine_macros.svh =====
// assertion macros for the prime sieve engine
// used by prime_sieve_engine.sv; expects i_clk and i_rst_n in scope
`ifndef PRIME_SIEVE_ENGINE_MACROS_SVH
`define PRIME_SIEVE_ENGINE_MACROS_SVH

// same-cycle implication, off while reset is held
`define PSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define PSE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pse_pkg.sv =====
// shared types and constants for the prime sieve engine
// no dependencies
package pse_pkg;

    localparam int LIM_W = 20;

    localparam logic FUNC_BUILD = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_BUILT   = 2'd1;
    localparam logic [1:0] ST_ABOVE_LIMIT = 2'd2;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 20'hFFFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_SQ,
        S_TEST,
        S_MARK,
        S_DONE
    } t_state;

endpackage

// ===== design/prime_sieve_engine.sv =====
// channel   | handshake                | payload
// ----------+--------------------------+----------------------------
// input     | i_valid / o_stall        | i_func, i_value
// output    | o_valid / i_stall        | o_is_prime, o_status
// config    | i_cfg_valid / o_cfg_ready| i_cfg_sieve_limit
//
// a query beat is taken every cycle while o_stall is low; its result passes the bit memory
// read register, then the output register. a build writes entries 0 to lim, then squares
// and reads each tested p, and clears its multiples one write at a time through the single
// write port of the bit memory. reset is synchronous; the bit memory has no clearing
// pass. the output register lets a new query enter while the previous result is stalled.
// depends on pse_pkg and prime_sieve_engine_macros.svh
`include "prime_sieve_engine_macros.svh"

module prime_sieve_engine
    import pse_pkg::*;
#(
    parameter int MAX_N = 1048576
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_func,
    input  logic [LIM_W-1:0] i_value,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_is_prime,
    output logic [1:0]       o_status,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [LIM_W-1:0] i_cfg_sieve_limit
);

    localparam int AW  = $clog2(MAX_N);
    localparam int CW  = (AW > LIM_W) ? AW : LIM_W;
    localparam int SQW = 2 * AW;

    t_state r_state, n_state;

    logic [LIM_W-1:0] r_limit;
    logic [AW-1:0]    r_lim_eff;
    logic [AW-1:0]    r_built_lim;
    logic             r_built;
    logic [AW-1:0]    r_idx;
    logic [AW-1:0]    r_p;
    logic [SQW-1:0]   r_sq;
    logic [AW-1:0]    r_m;

    logic             r_q_valid;
    logic [1:0]       r_q_status;
    logic             r_q_rd;
    logic             r_o_valid;
    logic             r_o_prime;
    logic [1:0]       r_o_status;

    logic             mem [MAX_N];
    logic             r_rd;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic             mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;

    logic             out_take, out_free, q_adv, q_free;
    logic             in_acc, q_acc, b_acc;
    logic [AW-1:0]    lim_clamp;
    logic [1:0]       q_status;
    logic             sq_over;
    logic [AW:0]      m_next;
    logic             m_over;

    // handshake plumbing
    assign out_take = r_o_valid && !i_stall;
    assign out_free = !r_o_valid || out_take;
    assign q_adv    = r_q_valid && out_free;
    assign q_free   = !r_q_valid || out_free;

    // a build waits for the query slot to drain so its reads cannot clobber r_rd
    assign o_stall  = (r_state != S_IDLE) || !q_free || (i_func == FUNC_BUILD && r_q_valid);
    assign in_acc   = i_valid && !o_stall;
    assign q_acc    = in_acc && (i_func == FUNC_QUERY);
    assign b_acc    = in_acc && (i_func == FUNC_BUILD);

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_o_valid;
    assign o_is_prime  = r_o_prime;
    assign o_status    = r_o_status;

    assign lim_clamp = (CW'(r_limit) > CW'(MAX_N - 1)) ? AW'(MAX_N - 1) : AW'(r_limit);

    always_comb begin
        if (!r_built) begin
            q_status = ST_NOT_BUILT;
        end else if (CW'(i_value) > CW'(r_built_lim)) begin
            q_status = ST_ABOVE_LIMIT;
        end else begin
            q_status = ST_OK;
        end
    end

    assign sq_over = r_sq > SQW'(r_lim_eff);
    assign m_next  = (AW + 1)'(r_m) + (AW + 1)'(r_p);
    assign m_over  = m_next > (AW + 1)'(r_lim_eff);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (b_acc) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (r_idx == r_lim_eff) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_state = S_TEST;
            end
            S_TEST: begin
                if (sq_over) begin
                    n_state = S_DONE;
                end else if (r_rd) begin
                    n_state = S_MARK;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_MARK: begin
                if (m_over) begin
                    n_state = S_SQ;
                end
            end
            S_DONE: begin
                if (q_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memory port controls
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = AW'(i_value);
        case (r_state)
            S_IDLE: begin
                mem_re = q_acc;
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_wdata = (r_idx >= AW'(2));
            end
            S_SQ: begin
                mem_re    = 1'b1;
                mem_raddr = r_p;
            end
            S_MARK: begin
                mem_we    = 1'b1;
                mem_waddr = r_m;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= mem[mem_raddr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_limit   <= LIMIT_RESET;
            r_built   <= 1'b0;
            r_q_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_sieve_limit;
            end
            if (r_state == S_DONE && q_free) begin
                r_built <= 1'b1;
            end
            if (q_acc || (r_state == S_DONE && q_free)) begin
                r_q_valid <= 1'b1;
            end else if (q_adv) begin
                r_q_valid <= 1'b0;
            end
            if (q_adv) begin
                r_o_valid <= 1'b1;
            end else if (out_take) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (b_acc) begin
            r_lim_eff <= lim_clamp;
            r_idx     <= '0;
        end
        if (r_state == S_FILL) begin
            r_idx <= r_idx + AW'(1);
            r_p   <= AW'(2);
        end
        if (r_state == S_SQ) begin
            r_sq <= SQW'(r_p) * SQW'(r_p);
        end
        if (r_state == S_TEST && !sq_over) begin
            if (r_rd) begin
                r_m <= r_sq[AW-1:0];
            end else begin
                r_p <= r_p + AW'(1);
            end
        end
        if (r_state == S_MARK) begin
            if (m_over) begin
                r_p <= r_p + AW'(1);
            end else begin
                r_m <= m_next[AW-1:0];
            end
        end
        if (r_state == S_DONE && q_free) begin
            r_built_lim <= r_lim_eff;
            r_q_status  <= ST_OK;
            r_q_rd      <= 1'b0;
        end else if (q_acc) begin
            r_q_status <= q_status;
            r_q_rd     <= (q_status == ST_OK);
        end
        if (q_adv) begin
            r_o_status <= r_q_status;
            r_o_prime  <= r_q_rd & r_rd;
        end
    end

    `PSE_ASSERT_NOW(a_mark_in_range, r_state == S_MARK, r_m <= r_lim_eff, "mark address above limit")
    `PSE_ASSERT_NOW(a_slot_empty_in_build, r_state != S_IDLE && r_state != S_DONE, !r_q_valid, "query slot busy during build")
    `PSE_ASSERT_NXT(a_query_enters, q_acc, r_q_valid && r_state == S_IDLE, "accepted query not in slot")

endmodule

// ===== verif/tb_prime_sieve_engine.sv =====
// self-checking testbench for prime_sieve_engine: build and query beats against a local sieve
// depends on pse_pkg and the prime_sieve_engine rtl
module tb_prime_sieve_engine
    import pse_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STORE_N = 1048576;
    // one full-store build is by far the longest phase, everything else is far below it
    localparam int unsigned CYCLE_LIMIT = 20000000;
    localparam int unsigned RANDOM_BEATS = 1600;

    typedef struct packed {
        logic       is_prime;
        logic [1:0] status;
    } t_answer;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic             i_func = FUNC_QUERY;
    logic [LIM_W-1:0] i_value = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic             o_is_prime;
    logic [1:0]       o_status;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [LIM_W-1:0] i_cfg_sieve_limit = LIMIT_RESET;

    // local copy of the engine state
    bit               prime_map [0:STORE_N-1];
    bit               have_sieve = 1'b0;
    int unsigned      sieve_top = 0;
    int unsigned      cfg_limit = 32'(LIMIT_RESET);

    // newest answer at the front, oldest at the back
    t_answer          pending_answers [$];
    int unsigned      mismatch_count = 0;
    int unsigned      beats_sent = 0;
    int unsigned      cycle_count = 0;
    int unsigned      stall_left = 0;
    bit               steady = 1'b0;

    prime_sieve_engine #(
        .MAX_N(STORE_N)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_value          (i_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_is_prime       (o_is_prime),
        .o_status         (o_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_sieve_limit(i_cfg_sieve_limit)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_answers.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void sieve_rebuild();
        int unsigned lim;
        int unsigned p;
        int unsigned m;
        lim = (cfg_limit > STORE_N - 1) ? STORE_N - 1 : cfg_limit;
        for (int unsigned i = 0; i <= lim; i++) prime_map[i] = 1'b1;
        prime_map[0] = 1'b0;
        if (lim >= 1) prime_map[1] = 1'b0;
        for (p = 2; p * p <= lim; p++) begin
            if (prime_map[p]) begin
                for (m = p * p; m <= lim; m += p) prime_map[m] = 1'b0;
            end
        end
        sieve_top = lim;
        have_sieve = 1'b1;
    endfunction

    function automatic t_answer primality_answer(logic func, logic [LIM_W-1:0] value);
        t_answer ans;
        ans.is_prime = 1'b0;
        ans.status = ST_OK;
        if (func == FUNC_BUILD) begin
            sieve_rebuild();
        end else if (!have_sieve) begin
            ans.status = ST_NOT_BUILT;
        end else if (32'(value) > sieve_top) begin
            ans.status = ST_ABOVE_LIMIT;
        end else begin
            ans.is_prime = prime_map[value];
        end
        return ans;
    endfunction

    // every call starts and ends just after a rising edge; valid stays high between beats in steady mode
    task automatic send_beat(input logic func, input logic [LIM_W-1:0] value);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= func;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
        pending_answers.push_front(primality_answer(func, value));
        beats_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [LIM_W-1:0] lim);
        drain_results();
        i_cfg_sieve_limit <= lim;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_limit = 32'(lim);
    endtask

    // result side: check each beat, then hold stall for a random count
    always @(posedge i_clk) begin : result_check
        t_answer want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_answers.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got is_prime %0b status %0d",
                         $time, o_is_prime, o_status);
                mismatch_count++;
            end else begin
                want = pending_answers.pop_back();
                if (o_is_prime !== want.is_prime) begin
                    $display("%0t ns: is_prime mismatch, expected %0b, got %0b",
                             $time, want.is_prime, o_is_prime);
                    mismatch_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t ns: status mismatch, expected %0d, got %0d",
                             $time, want.status, o_status);
                    mismatch_count++;
                end
            end
            stall_left = steady ? 0 : $urandom_range(0, 4);
        end
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic test_query_before_build();
        send_beat(FUNC_QUERY, '0);
        send_beat(FUNC_QUERY, 20'd1);
        send_beat(FUNC_QUERY, 20'd2);
        send_beat(FUNC_QUERY, LIMIT_RESET);
        send_beat(FUNC_QUERY, 20'($urandom_range(0, 20'hFFFFF)));
    endtask

    task automatic test_tiny_sieve();
        set_limit(20'd2);
        send_beat(FUNC_BUILD, LIMIT_RESET);
        send_beat(FUNC_QUERY, '0);
        send_beat(FUNC_QUERY, 20'd1);
        send_beat(FUNC_QUERY, 20'd2);
        send_beat(FUNC_QUERY, 20'd3);
        send_beat(FUNC_QUERY, LIMIT_RESET);
    endtask

    // a new limit takes effect only with the next build
    task automatic test_stale_limit();
        set_limit(20'd97);
        send_beat(FUNC_BUILD, '0);
        set_limit(20'd1000);
        send_beat(FUNC_QUERY, 20'd97);
        send_beat(FUNC_QUERY, 20'd98);
        send_beat(FUNC_QUERY, 20'd500);
        send_beat(FUNC_BUILD, 20'd5);
        send_beat(FUNC_QUERY, 20'd997);
        send_beat(FUNC_QUERY, 20'd1000);
        send_beat(FUNC_QUERY, 20'd1001);
    endtask

    task automatic test_full_store();
        set_limit(LIMIT_RESET);
        send_beat(FUNC_BUILD, '0);
        send_beat(FUNC_QUERY, LIMIT_RESET);
        send_beat(FUNC_QUERY, 20'd1048573);
        send_beat(FUNC_QUERY, 20'd524287);
        send_beat(FUNC_QUERY, 20'd1);
    endtask

    task automatic test_random_phases();
        int unsigned lim;
        int unsigned count;
        int unsigned pick;
        int unsigned target;
        target = beats_sent + RANDOM_BEATS;
        while (beats_sent < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) lim = $urandom_range(2, 300);
            else if (pick < 9) lim = $urandom_range(301, 5000);
            else lim = $urandom_range(5001, 40000);
            set_limit(LIM_W'(lim));
            steady = ($urandom_range(0, 3) == 0);
            send_beat(FUNC_BUILD, LIM_W'($urandom_range(0, 20'hFFFFF)));
            count = $urandom_range(60, 140);
            for (int unsigned k = 0; k < count; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 2) begin
                    send_beat(FUNC_BUILD, LIM_W'($urandom_range(0, 20'hFFFFF)));
                end else if (pick < 17) begin
                    send_beat(FUNC_QUERY, LIM_W'($urandom_range(0, 20'hFFFFF)));
                end else if (pick < 22) begin
                    // right around the edge of the sieve
                    send_beat(FUNC_QUERY, LIM_W'(lim + $urandom_range(0, 2) - 1));
                end else begin
                    send_beat(FUNC_QUERY, LIM_W'($urandom_range(0, lim)));
                end
            end
            steady = 1'b0;
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_query_before_build();
        test_tiny_sieve();
        test_stale_limit();
        test_full_store();
        test_random_phases();

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
